@@ rtl/tpaw_pkg.sv @@
// tpaw_pkg: shared types, constants and stride helpers of the tensor permute address walker
// no dependencies; used by every module under rtl
`default_nettype none

package tpaw_pkg;

    localparam int OFFSET_BITS    = 32;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_REG_DIMS   = 4;
    localparam int ORDER_BITS     = 4;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [ORDER_BITS-1:0]  order_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DIMS_USED       = 3'd0,
        REG_DIM_SIZES       = 3'd1,
        REG_PERM_MAP        = 3'd2,
        REG_SRC_STRIDE_LOW  = 3'd3,
        REG_SRC_STRIDE_HIGH = 3'd4,
        REG_DST_STRIDE_LOW  = 3'd5,
        REG_DST_STRIDE_HIGH = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]  dims_used;
        logic [63:0] dim_sizes;
        logic [7:0]  perm_map;
        logic [63:0] src_stride_low;
        logic [63:0] src_stride_high;
        logic [63:0] dst_stride_low;
        logic [63:0] dst_stride_high;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dims_used:       3'd1,
        dim_sizes:       64'h0001_0001_0001_0001,
        perm_map:        8'hE4,
        src_stride_low:  64'h0000_0001_0000_0001,
        src_stride_high: 64'h0000_0001_0000_0001,
        dst_stride_low:  64'h0000_0001_0000_0001,
        dst_stride_high: 64'h0000_0001_0000_0001
    };

    // 32-bit stride of dimension d out of a low/high register pair
    function automatic offset_t pair_field(logic [63:0] lo, logic [63:0] hi, logic [1:0] d);
        logic [63:0] w;
        w = d[1] ? hi : lo;
        return d[0] ? w[63:32] : w[31:0];
    endfunction

    function automatic offset_t src_stride(cfg_t c, logic [1:0] d);
        return pair_field(c.src_stride_low, c.src_stride_high, d);
    endfunction

    // highest used destination dim fed by source dim d wins; none gives zero
    function automatic offset_t dst_stride(cfg_t c, logic [1:0] d, order_t n);
        offset_t s;
        s = '0;
        for (int j = 0; j < NUM_REG_DIMS; j++)
        begin
            if (ORDER_BITS'(j) < n && c.perm_map[2*j +: 2] == d)
                s = pair_field(c.dst_stride_low, c.dst_stride_high, 2'(j));
        end
        return s;
    endfunction

    // dims in use, clamped to 1..4 and to the build's maximum order
    function automatic order_t order_of(logic [2:0] dims_used, order_t max_order);
        order_t n;
        if (dims_used == 3'd0)
            n = ORDER_BITS'(1);
        else if (dims_used > 3'd4)
            n = ORDER_BITS'(NUM_REG_DIMS);
        else
            n = {1'b0, dims_used};
        if (n > max_order)
            n = max_order;
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tensor_permute_address_walker.sv @@
// tensor_permute_address_walker: streams tensor elements and tags each with its offsets
// an accepted word passes the capture, multiply and sum registers, in that order
// throughput: one word per cycle while tready is high; three-stage capture/multiply/sum pipe
// a stage holds only when it and all later stages are full and the master holds tready low
// reset: asynchronous active low; index counters and valids clear, registers take defaults
// depends on tpaw_pkg, tpaw_index_walker, tpaw_offset_pipe
`default_nettype none

module tensor_permute_address_walker #(
    parameter int MAX_ORDER = 4,
    parameter int SIZE_BITS = 16,
    parameter int DATA_BITS = 64
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    // element stream in
    input  wire logic                                        s_axis_tvalid,
    output logic                                             s_axis_tready,
    // element_in
    input  wire logic [((DATA_BITS+7)/8)*8-1:0]              s_axis_tdata,
    // offset-tagged stream out
    output logic                                             m_axis_tvalid,
    input  wire logic                                        m_axis_tready,
    // source_offset, dest_offset, element_out
    output logic [((2*tpaw_pkg::OFFSET_BITS+DATA_BITS+7)/8)*8-1:0] m_axis_tdata,
    // last_element
    output logic                                             m_axis_tlast,
    // register writes
    input  wire logic                                        cfg_valid,
    output logic                                             cfg_ready,
    input  wire logic [tpaw_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  wire logic [tpaw_pkg::CFG_DATA_BITS-1:0]          cfg_data
);

    localparam int OUT_W = ((2*tpaw_pkg::OFFSET_BITS+DATA_BITS+7)/8)*8;

    tpaw_pkg::cfg_t                       cfg_reg;
    tpaw_pkg::order_t                     order;
    logic                                 step;
    logic                                 pipe_ready;
    logic [MAX_ORDER-1:0][SIZE_BITS-1:0]  idx;
    logic                                 last;
    tpaw_pkg::offset_t                    out_src;
    tpaw_pkg::offset_t                    out_dst;
    logic [DATA_BITS-1:0]                 out_elem;

    // registers always take a write; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= tpaw_pkg::CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpaw_pkg::REG_DIMS_USED:       cfg_reg.dims_used       <= cfg_data[2:0];
                tpaw_pkg::REG_DIM_SIZES:       cfg_reg.dim_sizes       <= cfg_data;
                tpaw_pkg::REG_PERM_MAP:        cfg_reg.perm_map        <= cfg_data[7:0];
                tpaw_pkg::REG_SRC_STRIDE_LOW:  cfg_reg.src_stride_low  <= cfg_data;
                tpaw_pkg::REG_SRC_STRIDE_HIGH: cfg_reg.src_stride_high <= cfg_data;
                tpaw_pkg::REG_DST_STRIDE_LOW:  cfg_reg.dst_stride_low  <= cfg_data;
                tpaw_pkg::REG_DST_STRIDE_HIGH: cfg_reg.dst_stride_high <= cfg_data;
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // number of dims walked, clamped to the supported range
    assign order = tpaw_pkg::order_of(cfg_reg.dims_used,
                                      tpaw_pkg::ORDER_BITS'(MAX_ORDER));

    assign s_axis_tready = pipe_ready;
    assign step          = s_axis_tvalid && pipe_ready;

    // counters advance on every accepted word; the pipe captures the pre-step indices
    tpaw_index_walker #(
        .MAX_ORDER (MAX_ORDER),
        .SIZE_BITS (SIZE_BITS)
    ) u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .order (order),
        .step  (step),
        .idx   (idx),
        .last  (last)
    );

    tpaw_offset_pipe #(
        .MAX_ORDER (MAX_ORDER),
        .SIZE_BITS (SIZE_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .order     (order),
        .in_valid  (s_axis_tvalid),
        .in_ready  (pipe_ready),
        .in_elem   (s_axis_tdata[DATA_BITS-1:0]),
        .in_idx    (idx),
        .in_last   (last),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_src   (out_src),
        .out_dst   (out_dst),
        .out_elem  (out_elem),
        .out_last  (m_axis_tlast)
    );

    // pack source offset lowest, then destination offset, then the element
    assign m_axis_tdata = OUT_W'({out_elem, out_dst, out_src});

endmodule

`default_nettype wire

@@ rtl/tpaw_index_walker.sv @@
// tpaw_index_walker: multi-dimensional index counter with carry ripple and wrap
// depends on tpaw_pkg
`default_nettype none

module tpaw_index_walker #(
    parameter int MAX_ORDER = 4,
    parameter int SIZE_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire tpaw_pkg::cfg_t                       cfg,
    input  wire tpaw_pkg::order_t                     order,
    input  wire logic                                 step,
    output logic [MAX_ORDER-1:0][SIZE_BITS-1:0]       idx,
    output logic                                      last
);

    logic [MAX_ORDER-1:0][SIZE_BITS-1:0] idx_reg;
    logic [MAX_ORDER-1:0][SIZE_BITS-1:0] idx_next;

    logic [63:0]          sh;
    logic [SIZE_BITS-1:0] ext;
    logic [SIZE_BITS:0]   bump;
    logic                 active;
    logic                 wrap;
    logic                 carry;

    always_comb
    begin
        idx_next = idx_reg;
        carry    = 1'b1;
        last     = 1'b0;
        sh       = '0;
        ext      = '0;
        bump     = '0;
        active   = 1'b0;
        wrap     = 1'b0;
        for (int d = 0; d < MAX_ORDER; d++)
        begin
            sh   = cfg.dim_sizes >> (d * SIZE_BITS);
            ext  = sh[SIZE_BITS-1:0];
            if (ext == '0)
                ext = SIZE_BITS'(1);
            bump   = {1'b0, idx_reg[d]} + (SIZE_BITS+1)'(1);
            active = tpaw_pkg::ORDER_BITS'(d) < order;
            // reaching or passing the extent carries into the next dim
            wrap   = carry && active && (bump >= {1'b0, ext});
            if (wrap)
                idx_next[d] = '0;
            else if (carry && active)
                idx_next[d] = bump[SIZE_BITS-1:0];
            if (wrap && tpaw_pkg::ORDER_BITS'(d + 1) == order)
                last = 1'b1;
            carry = wrap;
        end
        // end of tensor: restart, unused dims included
        if (last)
            idx_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (step)
            idx_reg <= idx_next;
    end

    assign idx = idx_reg;

    a_restart_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> idx_reg == '0)
        else $error("walk did not restart after the last element");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(idx_reg))
        else $error("index counters moved without an element");

endmodule

`default_nettype wire

@@ rtl/tpaw_offset_pipe.sv @@
// tpaw_offset_pipe: capture, multiply and sum stages that form source and destination offsets
// depends on tpaw_pkg
`default_nettype none

module tpaw_offset_pipe #(
    parameter int MAX_ORDER = 4,
    parameter int SIZE_BITS = 16,
    parameter int DATA_BITS = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire tpaw_pkg::cfg_t                       cfg,
    input  wire tpaw_pkg::order_t                     order,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [DATA_BITS-1:0]                 in_elem,
    input  wire logic [MAX_ORDER-1:0][SIZE_BITS-1:0]  in_idx,
    input  wire logic                                 in_last,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output tpaw_pkg::offset_t                         out_src,
    output tpaw_pkg::offset_t                         out_dst,
    output logic [DATA_BITS-1:0]                      out_elem,
    output logic                                      out_last
);

    localparam int LANES = (MAX_ORDER < tpaw_pkg::NUM_REG_DIMS) ?
                           MAX_ORDER : tpaw_pkg::NUM_REG_DIMS;

    // stage 1: captured word with its index snapshot
    logic                                 valid1_reg;
    logic [DATA_BITS-1:0]                 elem1_reg;
    logic [MAX_ORDER-1:0][SIZE_BITS-1:0]  idx1_reg;
    logic                                 last1_reg;
    // stage 2: per-dimension products
    logic                                 valid2_reg;
    logic [DATA_BITS-1:0]                 elem2_reg;
    tpaw_pkg::offset_t [LANES-1:0]        sprod2_reg;
    tpaw_pkg::offset_t [LANES-1:0]        dprod2_reg;
    tpaw_pkg::offset_t [LANES-1:0]        sprod2_next;
    tpaw_pkg::offset_t [LANES-1:0]        dprod2_next;
    logic                                 last2_reg;
    // stage 3: result register
    logic                                 valid3_reg;
    logic [DATA_BITS-1:0]                 elem3_reg;
    tpaw_pkg::offset_t                    src3_reg;
    tpaw_pkg::offset_t                    dst3_reg;
    tpaw_pkg::offset_t                    src3_next;
    tpaw_pkg::offset_t                    dst3_next;
    logic                                 last3_reg;

    logic adv1, adv2, adv3;

    assign adv3     = !valid3_reg || out_ready;
    assign adv2     = !valid2_reg || adv3;
    assign adv1     = !valid1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (tpaw_pkg::ORDER_BITS'(l) < order)
            begin
                sprod2_next[l] = tpaw_pkg::OFFSET_BITS'(idx1_reg[l]) *
                                 tpaw_pkg::src_stride(cfg, 2'(l));
                dprod2_next[l] = tpaw_pkg::OFFSET_BITS'(idx1_reg[l]) *
                                 tpaw_pkg::dst_stride(cfg, 2'(l), order);
            end
            else
            begin
                sprod2_next[l] = '0;
                dprod2_next[l] = '0;
            end
        end
    end

    always_comb
    begin
        src3_next = '0;
        dst3_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            src3_next = src3_next + sprod2_reg[l];
            dst3_next = dst3_next + dprod2_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                valid1_reg <= in_valid;
            if (adv2)
                valid2_reg <= valid1_reg;
            if (adv3)
                valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            elem1_reg <= in_elem;
            idx1_reg  <= in_idx;
            last1_reg <= in_last;
        end
        if (adv2)
        begin
            elem2_reg  <= elem1_reg;
            sprod2_reg <= sprod2_next;
            dprod2_reg <= dprod2_next;
            last2_reg  <= last1_reg;
        end
        if (adv3)
        begin
            elem3_reg <= elem2_reg;
            src3_reg  <= src3_next;
            dst3_reg  <= dst3_next;
            last3_reg <= last2_reg;
        end
    end

    assign out_valid = valid3_reg;
    assign out_src   = src3_reg;
    assign out_dst   = dst3_reg;
    assign out_elem  = elem3_reg;
    assign out_last  = last3_reg;

    a_stage2_loads: assert property (@(posedge clk) disable iff (!rst_n)
        valid1_reg && adv2 |=> valid2_reg)
        else $error("word lost between capture and multiply stages");

    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid2_reg && !adv3 |=> valid2_reg && $stable(sprod2_reg) && $stable(dprod2_reg))
        else $error("stalled products changed");

endmodule

`default_nettype wire

@@ dv/tb_tensor_permute_address_walker.sv @@
`timescale 1ns / 100ps
// tb_tensor_permute_address_walker: self-checking bench for the tensor permute address walker
// a scoreboard class keeps its own walk state and predicts offsets and the last flag per word
// depends on tpaw_pkg and rtl/tensor_permute_address_walker.sv

module tb_tensor_permute_address_walker;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int ITEM_TARGET  = 1900;
    localparam int DRAIN_CYCLES = 8;
    // covers the slowest legal run, roughly 2000 words with gaps and stalls, several times over
    localparam int CYCLE_LIMIT  = 600000;
    // register index with nothing behind it, writes there must change nothing
    localparam logic [tpaw_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;

    // one expected word on the master side
    typedef struct packed {
        logic [31:0] source_offset;
        logic [31:0] dest_offset;
        logic [63:0] element;
        logic        last;
    } walk_word_t;

    // keeps a private copy of registers and index counters and predicts every output word
    class walk_scoreboard;
        tpaw_pkg::cfg_t regs;
        logic [15:0]    idx [4];
        walk_word_t     expected_words [$];
        int             errors;

        function new();
            regs.dims_used       = 3'd1;
            regs.dim_sizes       = 64'h0001_0001_0001_0001;
            regs.perm_map        = 8'hE4;
            regs.src_stride_low  = 64'h0000_0001_0000_0001;
            regs.src_stride_high = 64'h0000_0001_0000_0001;
            regs.dst_stride_low  = 64'h0000_0001_0000_0001;
            regs.dst_stride_high = 64'h0000_0001_0000_0001;
            foreach (idx[d])
                idx[d] = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void write_reg(logic [2:0] r, logic [63:0] v);
            case (r)
                tpaw_pkg::REG_DIMS_USED:       regs.dims_used       = v[2:0];
                tpaw_pkg::REG_DIM_SIZES:       regs.dim_sizes       = v;
                tpaw_pkg::REG_PERM_MAP:        regs.perm_map        = v[7:0];
                tpaw_pkg::REG_SRC_STRIDE_LOW:  regs.src_stride_low  = v;
                tpaw_pkg::REG_SRC_STRIDE_HIGH: regs.src_stride_high = v;
                tpaw_pkg::REG_DST_STRIDE_LOW:  regs.dst_stride_low  = v;
                tpaw_pkg::REG_DST_STRIDE_HIGH: regs.dst_stride_high = v;
                default: ;
            endcase
        endfunction

        // dimensions actually walked, out-of-range counts clamp to 1..4
        function int walk_order();
            if (regs.dims_used == 3'd0)
                return 1;
            if (regs.dims_used > 3'd4)
                return 4;
            return int'(regs.dims_used);
        endfunction

        function logic [31:0] stride_of(logic [63:0] lo, logic [63:0] hi, int k);
            logic [63:0] w;
            w = (k >= 2) ? hi : lo;
            return w[32*(k%2) +: 32];
        endfunction

        function void current_offsets(output logic [31:0] so, output logic [31:0] dofs);
            int          n;
            logic [31:0] ds;
            n    = walk_order();
            so   = '0;
            dofs = '0;
            for (int d = 0; d < n; d++)
            begin
                // last matching destination dim wins, no match adds nothing
                ds = '0;
                for (int j = 0; j < n; j++)
                    if (regs.perm_map[2*j +: 2] == 2'(d))
                        ds = stride_of(regs.dst_stride_low, regs.dst_stride_high, j);
                so   = so + 32'(idx[d]) * stride_of(regs.src_stride_low, regs.src_stride_high, d);
                dofs = dofs + 32'(idx[d]) * ds;
            end
        endfunction

        function void note_element(logic [63:0] e);
            walk_word_t  w;
            logic [31:0] so, dofs;
            logic [16:0] nxt, ext;
            int          n, d;
            current_offsets(so, dofs);
            w.source_offset = so;
            w.dest_offset   = dofs;
            w.element       = e;
            n = walk_order();
            d = 0;
            // ripple carry, a zero extent acts as one and an index at or past it carries
            while (d < n)
            begin
                ext = {1'b0, regs.dim_sizes[16*d +: 16]};
                if (ext == '0)
                    ext = 17'd1;
                nxt = {1'b0, idx[d]} + 17'd1;
                if (nxt >= ext)
                begin
                    idx[d] = '0;
                    d++;
                end
                else
                begin
                    idx[d] = nxt[15:0];
                    break;
                end
            end
            w.last = (d >= n);
            if (w.last)
                foreach (idx[k])
                    idx[k] = '0;
            expected_words.push_back(w);
        endfunction

        function void check_word(logic [127:0] data, logic last);
            walk_word_t w;
            if (expected_words.size() == 0)
            begin
                $error("output word with nothing expected: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (data[31:0] !== w.source_offset)
            begin
                $error("source_offset: expected %h, actual %h", w.source_offset, data[31:0]);
                errors++;
            end
            if (data[63:32] !== w.dest_offset)
            begin
                $error("dest_offset: expected %h, actual %h", w.dest_offset, data[63:32]);
                errors++;
            end
            if (data[127:64] !== w.element)
            begin
                $error("element_out: expected %h, actual %h", w.element, data[127:64]);
                errors++;
            end
            if (last !== w.last)
            begin
                $error("last_element: expected %b, actual %b", w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b1;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid     = 1'b0;
    logic         cfg_ready;
    logic [tpaw_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [tpaw_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    walk_scoreboard sb;
    int             items_sent  = 0;
    int             cycle_count = 0;
    int             rx_hold     = 0;
    bit             tx_burst    = 1'b0;   // sender runs with no gaps
    bit             rx_stalls   = 1'b1;   // receiver drops tready at random
    logic [tpaw_pkg::CFG_INDEX_BITS-1:0] cfg_idx_q [$];
    logic [tpaw_pkg::CFG_DATA_BITS-1:0]  cfg_val_q [$];

    tensor_permute_address_walker #(
        .MAX_ORDER (4),
        .SIZE_BITS (16),
        .DATA_BITS (64)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // element_in
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // source_offset, dest_offset, element_out
        .m_axis_tlast  (m_axis_tlast),    // last_element
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** tensor_permute_address_walker: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin
        if (rx_hold != 0)
            rx_hold = rx_hold - 1;
        else if (rx_stalls && $urandom_range(0, 99) < 30)
        begin
            m_axis_tready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                rx_hold = $urandom_range(10, 40);
            else
                rx_hold = $urandom_range(0, 2);
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold = $urandom_range(0, 5);
        end
    end

    // handshake monitor: output words are checked before the same edge's input is noted,
    // since an input can never come out at the edge it is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_element(s_axis_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // send one element word; valid stays high into the next word when gap is zero
    task automatic send_element(input logic [63:0] data, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stage_reg(input logic [tpaw_pkg::CFG_INDEX_BITS-1:0] r,
                             input logic [63:0] v);
        cfg_idx_q.push_back(r);
        cfg_val_q.push_back(v);
    endtask

    task automatic stage_every(input logic [63:0] v);
        tpaw_pkg::cfg_reg_t r;
        r = r.first();
        do
        begin
            stage_reg(r, v);
            r = r.next();
        end
        while (r != r.first());
    endtask

    // back-to-back register writes, valid dropped only after the last one
    task automatic apply_regs();
        while (cfg_idx_q.size() != 0)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_q.pop_front();
            cfg_data  <= cfg_val_q.pop_front();
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // all expected words back, then a drain wait past the capture, multiply and sum registers
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int next_gap();
        int r;
        if (tx_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] random_element();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] random_stride();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 32'($urandom_range(0, 64));
        if (r < 80)
            return 32'($urandom);
        if (r < 90)
            return '1;
        return '0;
    endfunction

    // mostly small extents so the walk wraps often, sometimes zero or huge
    function automatic logic [15:0] random_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 16'($urandom_range(1, 5));
        if (r < 85)
            return '0;
        if (r < 92)
            return '1;
        return 16'($urandom);
    endfunction

    // new register settings; a random subset unless every register is asked for
    task automatic roll_config(input bit write_all);
        logic [1:0]  p [4];
        logic [1:0]  t;
        logic [63:0] v;
        int          j;
        if (write_all || $urandom_range(0, 9) < 6)
        begin
            v = {$urandom, $urandom};
            if ($urandom_range(0, 4) != 0)
                v[2:0] = 3'($urandom_range(1, 4));
            stage_reg(tpaw_pkg::REG_DIMS_USED, v);
        end
        if (write_all || $urandom_range(0, 9) < 6)
            stage_reg(tpaw_pkg::REG_DIM_SIZES,
                      {random_extent(), random_extent(), random_extent(), random_extent()});
        if (write_all || $urandom_range(0, 9) < 6)
        begin
            // usually a true permutation, otherwise any byte
            for (int i = 0; i < 4; i++)
                p[i] = 2'(i);
            for (int i = 3; i > 0; i--)
            begin
                j    = $urandom_range(0, i);
                t    = p[i];
                p[i] = p[j];
                p[j] = t;
            end
            v = {$urandom, $urandom};
            v[7:0] = {p[3], p[2], p[1], p[0]};
            if ($urandom_range(0, 3) == 0)
                v[7:0] = 8'($urandom_range(0, 255));
            stage_reg(tpaw_pkg::REG_PERM_MAP, v);
        end
        if (write_all || $urandom_range(0, 9) < 6)
            stage_reg(tpaw_pkg::REG_SRC_STRIDE_LOW, {random_stride(), random_stride()});
        if (write_all || $urandom_range(0, 9) < 6)
            stage_reg(tpaw_pkg::REG_SRC_STRIDE_HIGH, {random_stride(), random_stride()});
        if (write_all || $urandom_range(0, 9) < 6)
            stage_reg(tpaw_pkg::REG_DST_STRIDE_LOW, {random_stride(), random_stride()});
        if (write_all || $urandom_range(0, 9) < 6)
            stage_reg(tpaw_pkg::REG_DST_STRIDE_HIGH, {random_stride(), random_stride()});
        apply_regs();
    endtask

    // a run of random elements; at pause_at the sender holds off until the pipe is empty
    task automatic run_phase(input int count, input int pause_at);
        int gap;
        for (int i = 0; i < count; i++)
        begin
            gap = next_gap();
            // valid must be low before a hold-off or a register write
            if ((i == pause_at || i == count - 1) && gap == 0)
                gap = 1;
            send_element(random_element(), gap);
            if (i == pause_at)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        int count;
        int pause_at;
        bit first_roll;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one dimension of extent one, so every word is last at offset zero
        send_element('0, 0);
        send_element('1, 0);
        send_element({32{2'b01}}, 0);
        send_element({32{2'b10}}, 1);
        wait_drained();

        // three dims of 2x3x2 with a real permutation; one full tensor, last on the twelfth
        stage_reg(tpaw_pkg::REG_DIMS_USED, 64'd3);
        stage_reg(tpaw_pkg::REG_DIM_SIZES, 64'h0005_0002_0003_0002);
        stage_reg(tpaw_pkg::REG_PERM_MAP, 64'h0000_0000_0000_00D2);
        stage_reg(tpaw_pkg::REG_SRC_STRIDE_LOW, 64'h0000_0002_0000_0001);
        stage_reg(tpaw_pkg::REG_SRC_STRIDE_HIGH, 64'h0000_0007_0000_0006);
        stage_reg(tpaw_pkg::REG_DST_STRIDE_LOW, 64'h0000_0002_0000_0001);
        stage_reg(tpaw_pkg::REG_DST_STRIDE_HIGH, 64'h0000_0009_0000_0004);
        // unmapped index, must leave every register alone
        stage_reg(REG_UNMAPPED, 64'hFFFF_0000_FFFF_0000);
        apply_regs();
        run_phase(12, -1);

        // dims above four clamp to four, perm map all zero, all-ones strides wrap the sums
        stage_reg(tpaw_pkg::REG_DIMS_USED, '1);
        stage_reg(tpaw_pkg::REG_PERM_MAP, 64'hFFFF_FFFF_FFFF_FF00);
        stage_reg(tpaw_pkg::REG_SRC_STRIDE_HIGH, '1);
        stage_reg(tpaw_pkg::REG_DST_STRIDE_LOW, '1);
        stage_reg(tpaw_pkg::REG_DST_STRIDE_HIGH, '1);
        apply_regs();
        run_phase(5, -1);

        // dims zero acts as one, zero extent carries at once, index left past its new
        // extent still carries, and the stale upper indices clear on the restart
        stage_reg(tpaw_pkg::REG_DIMS_USED, 64'd0);
        stage_reg(tpaw_pkg::REG_DIM_SIZES, 64'h0003_0003_0003_0000);
        apply_regs();
        run_phase(2, -1);

        // extremes: everything at its maximum, then everything at zero
        stage_every('1);
        apply_regs();
        run_phase(40, 20);
        stage_every('0);
        apply_regs();
        run_phase(30, -1);

        // random settings and random traffic shapes until enough words have gone in
        first_roll = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            roll_config(first_roll);
            tx_burst  = ($urandom_range(0, 3) == 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            count     = $urandom_range(40, 250);
            pause_at  = -1;
            if (first_roll || $urandom_range(0, 2) == 0)
                pause_at = $urandom_range(0, count - 1);
            first_roll = 1'b0;
            run_phase(count, pause_at);
        end

        // nothing left in flight, then watch a while for stray words
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** tensor_permute_address_walker: PASSED **");
        else
            $display("** tensor_permute_address_walker: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tpaw_pkg.sv
rtl/tpaw_index_walker.sv
rtl/tpaw_offset_pipe.sv
rtl/tensor_permute_address_walker.sv
dv/tb_tensor_permute_address_walker.sv
